/* rtl/fsarm_pkg.sv */
// ----------------------------------------------------------------------------
// fsarm_pkg
// Types and constants shared by the fixed-step accumulator and rate meter.
// ----------------------------------------------------------------------------
package fsarm_pkg;

    localparam int unsigned MAX_STEPS_DEF = 63;
    localparam int unsigned FRAC_BITS_DEF = 24;

    localparam logic [31:0] STEP_LEN_RST = 32'd279620;

    // field widths
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned ACC_W   = 34;
    localparam int unsigned TOTAL_W = 48;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned PSC_W   = 20;
    localparam int unsigned WSTEP_W = 6;
    localparam int unsigned RATE_W  = 32;

    // divider dividend shift register: wide enough for the smoothing numerator
    localparam int unsigned DVD_W = 46;
    localparam int unsigned DN_W  = 14;

    // smoothing divisors, their weight (D-1) and rounding half (D/2)
    localparam logic [DN_W-1:0] DN_A   = 14'd10;
    localparam logic [DN_W-1:0] DN_B   = 14'd100;
    localparam logic [DN_W-1:0] DN_C   = 14'd1000;
    localparam logic [DN_W-1:0] DN_D   = 14'd10000;
    localparam logic [DN_W-1:0] DNM1_A = 14'd9;
    localparam logic [DN_W-1:0] DNM1_B = 14'd99;
    localparam logic [DN_W-1:0] DNM1_C = 14'd999;
    localparam logic [DN_W-1:0] DNM1_D = 14'd9999;
    localparam logic [DN_W-1:0] DNH_A  = 14'd5;
    localparam logic [DN_W-1:0] DNH_B  = 14'd50;
    localparam logic [DN_W-1:0] DNH_C  = 14'd500;
    localparam logic [DN_W-1:0] DNH_D  = 14'd5000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_INST,
        S_DIV_AVG,
        S_MUL,
        S_SUM,
        S_DIV_SMOOTH,
        S_ACCUM,
        S_STEP
    } t_state;

endpackage

/* rtl/fixed_step_accumulator_rate_meter_unit.sv */
// ----------------------------------------------------------------------------
// fixed_step_accumulator_rate_meter_unit
// Fixed-timestep accumulator: one word per frame time in, one word per fixed
// step plus an end-of-frame summary out, with step rate statistics.
// ----------------------------------------------------------------------------
// A frame time word is taken only while the unit is idle. If the previous
// frame produced steps, the rates are refreshed first by one shared restoring
// divider that yields one quotient bit per cycle: the instant rate, then the
// average rate, then the smoothed rate after a multiply and an add step, all
// before accumulation. Accumulation adds the frame time, then the step words
// and the summary word follow, held while the output side is stalled. A
// frame after one with no steps goes straight to accumulation.
// The step length register accepts a write every cycle; write it only when
// the unit is idle.
module fixed_step_accumulator_rate_meter_unit #(
    parameter int unsigned MAX_STEPS = fsarm_pkg::MAX_STEPS_DEF,
    parameter int unsigned FRAC_BITS = fsarm_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // step length register
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fsarm_pkg::TIME_W-1:0]      i_cfg_step_length,
    // frame time in
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [fsarm_pkg::TIME_W-1:0]      i_frame_time,
    // results out
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_is_step,
    output logic                              o_last,
    output logic [fsarm_pkg::CNT_W-1:0]       o_total_steps,
    output logic [fsarm_pkg::TOTAL_W-1:0]     o_simulated_time,
    output logic [fsarm_pkg::ACC_W-1:0]       o_leftover_time,
    output logic [fsarm_pkg::PSC_W-1:0]       o_steps_last_second,
    output logic [fsarm_pkg::RATE_W-1:0]      o_window_rate,
    output logic [fsarm_pkg::RATE_W-1:0]      o_average_rate,
    output logic [fsarm_pkg::RATE_W-1:0]      o_smoothed_rate
);
    import fsarm_pkg::*;

    localparam int unsigned RATE_ITERS   = 32 + FRAC_BITS + 8;
    localparam int unsigned SMOOTH_ITERS = DVD_W;
    localparam int unsigned ITER_MAX     = (RATE_ITERS > SMOOTH_ITERS) ? RATE_ITERS
                                                                       : SMOOTH_ITERS;
    localparam int unsigned ITER_W       = $clog2(ITER_MAX + 1);
    localparam int unsigned STEP_W       = $clog2(MAX_STEPS + 1);

    localparam logic [ACC_W-1:0]  ONE_SEC = ACC_W'(64'd1 << FRAC_BITS);
    localparam logic [TIME_W-1:0] THR_A   = TIME_W'((64'd12 << FRAC_BITS) / 64'd1000);
    localparam logic [TIME_W-1:0] THR_B   = TIME_W'((64'd4 << FRAC_BITS) / 64'd1000);
    localparam logic [TIME_W-1:0] THR_C   = TIME_W'((64'd4 << FRAC_BITS) / 64'd10000);

    // control and state
    t_state               r_state, n_state;
    logic [TIME_W-1:0]    r_step_len;
    logic [ACC_W-1:0]     r_acc;
    logic [CNT_W-1:0]     r_count;
    logic [TOTAL_W-1:0]   r_sim;
    logic [TOTAL_W-1:0]   r_wall;
    logic [ACC_W-1:0]     r_sec;
    logic [ACC_W-1:0]     r_win;
    logic [WSTEP_W-1:0]   r_wsteps;
    logic [CNT_W-1:0]     r_cnt_at_sec;
    logic [PSC_W-1:0]     r_per_sec;
    logic [RATE_W-1:0]    r_rate_inst;
    logic [RATE_W-1:0]    r_rate_avg;
    logic [RATE_W-1:0]    r_rate_smooth;
    logic [STEP_W-1:0]    r_steps;
    logic                 r_o_valid;

    // frame time and shared divider
    logic [TIME_W-1:0]    r_dt;
    logic [DVD_W-1:0]     r_dvd;
    logic [TOTAL_W-1:0]   r_dsr;
    logic [TOTAL_W-1:0]   r_rem;
    logic [RATE_W-1:0]    r_q;
    logic                 r_sat;
    logic [ITER_W-1:0]    r_iter;

    // output word
    logic                 r_o_is_step;
    logic                 r_o_last;
    logic [CNT_W-1:0]     r_o_total;
    logic [TOTAL_W-1:0]   r_o_sim;
    logic [ACC_W-1:0]     r_o_left;
    logic [PSC_W-1:0]     r_o_psc;
    logic [RATE_W-1:0]    r_o_inst;
    logic [RATE_W-1:0]    r_o_avg;
    logic [RATE_W-1:0]    r_o_smooth;

    // combinational
    logic                 in_acc;
    logic                 div_busy;
    logic [TOTAL_W:0]     rem_sh;
    logic                 rem_ge;
    logic [TOTAL_W:0]     rem_sub;
    logic [TOTAL_W-1:0]   rem_nx;
    logic                 rnd_up;
    logic [RATE_W:0]      q_inc;
    logic [RATE_W-1:0]    rate_res;
    logic [DN_W-1:0]      dn, dnm1, dnh;
    logic                 sec_due;
    logic [CNT_W-1:0]     sec_diff;
    logic [PSC_W-1:0]     psc_sat;
    logic [ACC_W:0]       acc_sum, sec_sum, win_sum;
    logic [TOTAL_W:0]     wall_sum;
    logic                 step_ok;
    logic                 out_free;
    logic [ACC_W-1:0]     step_acc;
    logic [CNT_W-1:0]     step_count;
    logic [TOTAL_W-1:0]   step_sim;

    assign in_acc   = i_valid && o_ready;
    assign div_busy = (r_iter != '0);
    assign out_free = !r_o_valid || i_ready;

    // restoring divider, one quotient bit per cycle
    assign rem_sh  = {r_rem, r_dvd[DVD_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_dsr};
    assign rem_sub = rem_sh - {1'b0, r_dsr};
    assign rem_nx  = rem_ge ? rem_sub[TOTAL_W-1:0] : rem_sh[TOTAL_W-1:0];

    // round half up on the final remainder, saturate to 32 bits
    assign rnd_up   = {r_rem, 1'b0} >= {1'b0, r_dsr};
    assign q_inc    = {1'b0, r_q} + {{RATE_W{1'b0}}, rnd_up};
    assign rate_res = (r_sat || q_inc[RATE_W]) ? '1 : q_inc[RATE_W-1:0];

    // stiffness of the moving average follows the frame time
    always_comb begin
        if (r_dt > THR_A) begin
            dn = DN_A;  dnm1 = DNM1_A;  dnh = DNH_A;
        end else if (r_dt > THR_B) begin
            dn = DN_B;  dnm1 = DNM1_B;  dnh = DNH_B;
        end else if (r_dt > THR_C) begin
            dn = DN_C;  dnm1 = DNM1_C;  dnh = DNH_C;
        end else begin
            dn = DN_D;  dnm1 = DNM1_D;  dnh = DNH_D;
        end
    end

    assign sec_due  = r_sec >= ONE_SEC;
    assign sec_diff = r_count - r_cnt_at_sec;
    assign psc_sat  = (sec_diff[CNT_W-1:PSC_W] != '0) ? '1 : sec_diff[PSC_W-1:0];

    assign acc_sum  = {1'b0, r_acc} + {3'b0, r_dt};
    assign sec_sum  = {1'b0, r_sec} + {3'b0, r_dt};
    assign win_sum  = {1'b0, r_win} + {3'b0, r_dt};
    assign wall_sum = {1'b0, r_wall} + {17'b0, r_dt};

    assign step_ok    = (r_steps < STEP_W'(MAX_STEPS)) && (r_step_len != '0)
                        && ({2'b0, r_step_len} <= r_acc);
    assign step_acc   = r_acc - {2'b0, r_step_len};
    assign step_count = r_count + CNT_W'(1);
    assign step_sim   = r_sim + {16'b0, r_step_len};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (r_wsteps != '0) ? S_DIV_INST : S_ACCUM;
                end
            end
            S_DIV_INST: begin
                if (!div_busy) n_state = S_DIV_AVG;
            end
            S_DIV_AVG: begin
                if (!div_busy) n_state = S_MUL;
            end
            S_MUL:        n_state = S_SUM;
            S_SUM:        n_state = S_DIV_SMOOTH;
            S_DIV_SMOOTH: begin
                if (!div_busy) n_state = S_ACCUM;
            end
            S_ACCUM:      n_state = S_STEP;
            S_STEP: begin
                if (out_free && !step_ok) n_state = S_IDLE;
            end
            default:      n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_ready     = (r_state == S_IDLE);
        o_cfg_ready = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_step_len    <= STEP_LEN_RST;
            r_acc         <= '0;
            r_count       <= '0;
            r_sim         <= '0;
            r_wall        <= '0;
            r_sec         <= '0;
            r_win         <= '0;
            r_wsteps      <= '0;
            r_cnt_at_sec  <= '0;
            r_per_sec     <= '0;
            r_rate_inst   <= '0;
            r_rate_avg    <= '0;
            r_rate_smooth <= '0;
            r_steps       <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                r_step_len <= i_cfg_step_length;
            end

            if (r_state == S_STEP && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc && sec_due) begin
                        r_per_sec    <= psc_sat;
                        r_cnt_at_sec <= r_count;
                        r_sec        <= '0;
                    end
                end
                S_DIV_INST: begin
                    if (!div_busy) r_rate_inst <= rate_res;
                end
                S_DIV_AVG: begin
                    if (!div_busy) r_rate_avg <= rate_res;
                end
                S_DIV_SMOOTH: begin
                    if (!div_busy) begin
                        r_rate_smooth <= r_q;
                        r_win         <= '0;
                    end
                end
                S_ACCUM: begin
                    r_acc    <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
                    r_sec    <= sec_sum[ACC_W] ? '1 : sec_sum[ACC_W-1:0];
                    r_win    <= win_sum[ACC_W] ? '1 : win_sum[ACC_W-1:0];
                    r_wall   <= wall_sum[TOTAL_W] ? '1 : wall_sum[TOTAL_W-1:0];
                    r_wsteps <= '0;
                    r_steps  <= '0;
                end
                S_STEP: begin
                    if (out_free && step_ok) begin
                        r_acc    <= step_acc;
                        r_count  <= step_count;
                        r_sim    <= step_sim;
                        r_wsteps <= r_wsteps + WSTEP_W'(1);
                        r_steps  <= r_steps + STEP_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // divider operands and output word
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_dt   <= i_frame_time;
                    r_dvd  <= {{(CNT_W-WSTEP_W){1'b0}}, r_wsteps, {(DVD_W-CNT_W){1'b0}}};
                    r_dsr  <= {{(TOTAL_W-ACC_W){1'b0}}, r_win};
                    r_rem  <= '0;
                    r_q    <= '0;
                    r_sat  <= 1'b0;
                    r_iter <= ITER_W'(RATE_ITERS);
                end
            end
            S_DIV_INST, S_DIV_AVG, S_DIV_SMOOTH: begin
                if (div_busy) begin
                    r_dvd  <= {r_dvd[DVD_W-2:0], 1'b0};
                    r_rem  <= rem_nx;
                    r_q    <= {r_q[RATE_W-2:0], rem_ge};
                    r_sat  <= r_sat | r_q[RATE_W-1];
                    r_iter <= r_iter - ITER_W'(1);
                end else if (r_state == S_DIV_INST) begin
                    r_dvd  <= {r_count, {(DVD_W-CNT_W){1'b0}}};
                    r_dsr  <= r_wall;
                    r_rem  <= '0;
                    r_q    <= '0;
                    r_sat  <= 1'b0;
                    r_iter <= ITER_W'(RATE_ITERS);
                end
            end
            S_MUL: begin
                r_dvd <= {{(DVD_W-RATE_W){1'b0}}, r_rate_smooth}
                         * {{(DVD_W-DN_W){1'b0}}, dnm1};
            end
            S_SUM: begin
                r_dvd  <= r_dvd + {{(DVD_W-RATE_W){1'b0}}, r_rate_inst}
                                + {{(DVD_W-DN_W){1'b0}}, dnh};
                r_dsr  <= {{(TOTAL_W-DN_W){1'b0}}, dn};
                r_rem  <= '0;
                r_q    <= '0;
                r_sat  <= 1'b0;
                r_iter <= ITER_W'(SMOOTH_ITERS);
            end
            S_STEP: begin
                if (out_free) begin
                    r_o_is_step <= step_ok;
                    r_o_last    <= !step_ok;
                    r_o_total   <= step_ok ? step_count : r_count;
                    r_o_sim     <= step_ok ? step_sim : r_sim;
                    r_o_left    <= step_ok ? step_acc : r_acc;
                    r_o_psc     <= r_per_sec;
                    r_o_inst    <= r_rate_inst;
                    r_o_avg     <= r_rate_avg;
                    r_o_smooth  <= r_rate_smooth;
                end
            end
            default: ;
        endcase
    end

    assign o_valid             = r_o_valid;
    assign o_is_step           = r_o_is_step;
    assign o_last              = r_o_last;
    assign o_total_steps       = r_o_total;
    assign o_simulated_time    = r_o_sim;
    assign o_leftover_time     = r_o_left;
    assign o_steps_last_second = r_o_psc;
    assign o_window_rate       = r_o_inst;
    assign o_average_rate      = r_o_avg;
    assign o_smoothed_rate     = r_o_smooth;

`ifndef SYNTH
    // a pending word always carries the live step count
    a_total_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_total_steps == r_count))
        else $error("pending word step count differs from counter");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_step != o_last))
        else $error("word is neither a step nor the summary");

    a_step_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (r_steps <= STEP_W'(MAX_STEPS)))
        else $error("steps per frame beyond cap");

    // smoothed quotient never exceeds 32 bits
    a_smooth_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_SMOOTH && !div_busy) |-> !r_sat)
        else $error("smoothed rate quotient overflowed");
`endif

endmodule
